// ===== hdl/nsp_pkg.sv =====
// nsp_pkg: shared constants, types and helper functions for the nmea sentence parser
// used by nsp_checksum, nsp_field_decoder and nmea_sentence_parser
`default_nettype none
package nsp_pkg;

    localparam int MAX_WORDS_DEF      = 32;
    localparam int MAX_WORD_CHARS_DEF = 16;

    localparam logic [7:0] C_DOLLAR = 8'h24;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_DOT    = 8'h2E;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_LF     = 8'h0A;
    localparam logic [7:0] C_ZERO   = 8'h30;
    localparam logic [7:0] C_SOUTH  = 8'h53;
    localparam logic [7:0] C_WEST   = 8'h57;
    localparam logic [7:0] C_VOID   = 8'h56;

    // header match codes
    localparam logic [1:0] HM_OTHER  = 2'd0;
    localparam logic [1:0] HM_GGA    = 2'd1;
    localparam logic [1:0] HM_RMC    = 2'd2;
    localparam logic [1:0] HM_PREFIX = 2'd3;

    // sentence kind codes
    localparam logic [1:0] KIND_GGA   = 2'd0;
    localparam logic [1:0] KIND_RMC   = 2'd1;
    localparam logic [1:0] KIND_OTHER = 2'd2;

    localparam int LAT_W = 27;
    localparam int LON_W = 28;
    localparam int MAG_W = 30;
    localparam logic [MAG_W-1:0] LAT_MAX = MAG_W'(54000000);
    localparam logic [MAG_W-1:0] LON_MAX = MAG_W'(108000000);

    // per-byte events from the framing logic
    typedef struct packed {
        logic       start;
        logic       take;
        logic [7:0] ch;
    } t_byte_ev;

    // decoded sentence fields with the final word closed
    typedef struct packed {
        logic [1:0]       hm;
        logic             fix;
        logic             south;
        logic             west;
        logic [6:0]       sats;
        logic [6:0]       hour;
        logic [6:0]       minute;
        logic [6:0]       second;
        logic [6:0]       day;
        logic [6:0]       month;
        logic [6:0]       year;
        logic [LAT_W-2:0] lat_mag;
        logic [LON_W-2:0] lon_mag;
    } t_fields;

    function automatic logic f_is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [3:0] f_digit(input logic [7:0] c);
        logic [7:0] d;
        d = c - C_ZERO;
        return f_is_digit(c) ? d[3:0] : 4'd0;
    endfunction

    // {valid, value} of one hex character
    function automatic logic [4:0] f_hex(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            return {1'b1, d[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    // quotient by 100 for values below 1000
    function automatic logic [3:0] f_div100(input logic [9:0] t);
        logic [3:0] q;
        q = 4'd0;
        for (int i = 1; i < 10; i++) begin
            if (t >= 10'(i * 100)) q = q + 4'd1;
        end
        return q;
    endfunction

    // weight of the next fraction digit in ten-thousandths
    function automatic logic [9:0] f_frac_weight(input logic [2:0] cnt);
        unique case (cnt)
            3'd1:    return 10'd1000;
            3'd2:    return 10'd100;
            3'd3:    return 10'd10;
            default: return 10'd1;
        endcase
    endfunction

    // expected header character at position k
    function automatic logic [7:0] f_hdr_char(input logic rmc, input logic [2:0] k);
        unique case (k)
            3'd0:    return C_DOLLAR;
            3'd1:    return 8'h47;
            3'd2:    return 8'h50;
            3'd3:    return rmc ? 8'h52 : 8'h47;
            3'd4:    return rmc ? 8'h4D : 8'h47;
            3'd5:    return rmc ? 8'h43 : 8'h41;
            default: return 8'h00;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== hdl/nsp_checksum.sv =====
// nsp_checksum: running xor between '$' and '*' and decode of the two hex digits after '*'
// depends on nsp_pkg
`default_nettype none
module nsp_checksum (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire nsp_pkg::t_byte_ev i_ev,
    output logic                   o_ok
);

    logic       r_in_region, n_in_region;
    logic       r_taking, n_taking;
    logic [7:0] r_calc, n_calc;
    logic [7:0] r_recv, n_recv;
    logic [1:0] r_cnt, n_cnt;
    logic [4:0] hex;

    assign hex  = nsp_pkg::f_hex(i_ev.ch);
    assign o_ok = (r_cnt == 2'd2) && (r_recv == r_calc);

    always_comb begin
        n_in_region = r_in_region;
        n_taking    = r_taking;
        n_calc      = r_calc;
        n_recv      = r_recv;
        n_cnt       = r_cnt;
        if (i_ev.start) begin
            n_in_region = 1'b1;
            n_taking    = 1'b0;
            n_calc      = 8'd0;
            n_recv      = 8'd0;
            n_cnt       = 2'd0;
        end else if (i_ev.take) begin
            n_in_region = r_in_region && (i_ev.ch != nsp_pkg::C_STAR);
            if (n_in_region) n_calc = r_calc ^ i_ev.ch;
            // count 3 marks a bad character
            if (r_taking && r_cnt < 2'd2) begin
                if (hex[4]) begin
                    n_recv = {r_recv[3:0], hex[3:0]};
                    n_cnt  = r_cnt + 2'd1;
                end else begin
                    n_cnt = 2'd3;
                end
            end
            if (i_ev.ch == nsp_pkg::C_STAR) n_taking = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_region <= 1'b0;
            r_taking    <= 1'b0;
            r_calc      <= 8'd0;
            r_recv      <= 8'd0;
            r_cnt       <= 2'd0;
        end else begin
            r_in_region <= n_in_region;
            r_taking    <= n_taking;
            r_calc      <= n_calc;
            r_recv      <= n_recv;
            r_cnt       <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/nsp_field_decoder.sv =====
// nsp_field_decoder: word splitting, header match and field accumulation
// depends on nsp_pkg
`default_nettype none
module nsp_field_decoder #(
    parameter int MAX_WORDS      = nsp_pkg::MAX_WORDS_DEF,
    parameter int MAX_WORD_CHARS = nsp_pkg::MAX_WORD_CHARS_DEF
) (
    input  wire logic              i_clk,
    input  wire nsp_pkg::t_byte_ev i_ev,
    output nsp_pkg::t_fields       o_fields
);

    localparam int WI_W  = $clog2(MAX_WORDS);
    localparam int CI_W  = $clog2(MAX_WORD_CHARS + 1);
    localparam int LM_W  = nsp_pkg::LAT_W - 1;
    localparam int NM_W  = nsp_pkg::LON_W - 1;

    logic [WI_W-1:0] r_word, n_word;
    logic [CI_W-1:0] r_char, n_char;
    logic [1:0]      r_hm, n_hm;
    logic [6:0]      r_td [6];
    logic [6:0]      n_td [6];
    logic [LM_W-1:0] r_lat, n_lat;
    logic [NM_W-1:0] r_lon, n_lon;
    logic            r_fix, n_fix;
    logic            r_south, n_south;
    logic            r_west, n_west;
    logic [6:0]      r_sats, n_sats;
    // numeric word: integer part as hundreds and remainder, fraction in 1/10000
    logic [2:0]      r_fcnt, n_fcnt;
    logic [9:0]      r_deg, n_deg;
    logic [6:0]      r_min, n_min;
    logic [13:0]     r_frac, n_frac;

    logic [nsp_pkg::MAG_W-1:0] mag, lat_sat, lon_sat;
    logic [1:0]      ew_hm;
    logic [LM_W-1:0] ew_lat;
    logic [NM_W-1:0] ew_lon;
    logic [6:0]      ew_sats;
    logic [7:0]      c;
    logic [3:0]      d;
    logic [9:0]      t;
    logic [3:0]      q;
    logic [13:0]     deg_next;
    logic [9:0]      min_next;
    logic [2:0]      slot;
    logic [2:0]      k3;
    logic            k_lt6;
    logic            k_zero;
    logic            is_gga;
    logic            is_rmc;

    assign c      = i_ev.ch;
    assign d      = nsp_pkg::f_digit(c);
    assign k_lt6  = r_char < CI_W'(6);
    assign k_zero = r_char == '0;
    assign k3     = r_char[2:0];
    assign slot   = {1'b0, r_char[2:1]};
    assign is_gga = r_hm == nsp_pkg::HM_GGA;
    assign is_rmc = r_hm == nsp_pkg::HM_RMC;
    assign t      = 10'(r_min) * 10'd10 + 10'(d);
    assign q      = nsp_pkg::f_div100(t);
    assign deg_next = 14'(r_deg) * 14'd10 + 14'(q);
    assign min_next = t - 10'(q) * 10'd100;

    // closing the current word
    always_comb begin
        mag = nsp_pkg::MAG_W'(r_deg) * nsp_pkg::MAG_W'(600000)
            + nsp_pkg::MAG_W'(r_min) * nsp_pkg::MAG_W'(10000)
            + nsp_pkg::MAG_W'(r_frac);
        lat_sat = (mag > nsp_pkg::LAT_MAX) ? nsp_pkg::LAT_MAX : mag;
        lon_sat = (mag > nsp_pkg::LON_MAX) ? nsp_pkg::LON_MAX : mag;
        ew_hm   = r_hm;
        ew_lat  = r_lat;
        ew_lon  = r_lon;
        ew_sats = r_sats;
        if (r_word == '0) begin
            if (r_char != CI_W'(6) || r_hm == nsp_pkg::HM_PREFIX) ew_hm = nsp_pkg::HM_OTHER;
        end else if (is_gga) begin
            if (r_word == WI_W'(2)) ew_lat = lat_sat[LM_W-1:0];
            else if (r_word == WI_W'(4)) ew_lon = lon_sat[NM_W-1:0];
            else if (r_word == WI_W'(7)) ew_sats = (r_deg != 10'd0) ? 7'd99 : r_min;
        end
    end

    always_comb begin
        o_fields.hm      = ew_hm;
        o_fields.fix     = r_fix;
        o_fields.south   = r_south;
        o_fields.west    = r_west;
        o_fields.sats    = ew_sats;
        o_fields.hour    = r_td[0];
        o_fields.minute  = r_td[1];
        o_fields.second  = r_td[2];
        o_fields.day     = r_td[3];
        o_fields.month   = r_td[4];
        o_fields.year    = r_td[5];
        o_fields.lat_mag = ew_lat;
        o_fields.lon_mag = ew_lon;
    end

    always_comb begin
        n_word  = r_word;
        n_char  = r_char;
        n_hm    = r_hm;
        n_td    = r_td;
        n_lat   = r_lat;
        n_lon   = r_lon;
        n_fix   = r_fix;
        n_south = r_south;
        n_west  = r_west;
        n_sats  = r_sats;
        n_fcnt  = r_fcnt;
        n_deg   = r_deg;
        n_min   = r_min;
        n_frac  = r_frac;
        if (i_ev.start) begin
            n_word  = '0;
            n_char  = CI_W'(1);
            n_hm    = nsp_pkg::HM_PREFIX;
            for (int i = 0; i < 6; i++) n_td[i] = 7'd0;
            n_lat   = '0;
            n_lon   = '0;
            n_fix   = 1'b1;
            n_south = 1'b0;
            n_west  = 1'b0;
            n_sats  = 7'd0;
            n_fcnt  = 3'd0;
            n_deg   = 10'd0;
            n_min   = 7'd0;
            n_frac  = 14'd0;
        end else if (i_ev.take) begin
            if (c == nsp_pkg::C_COMMA) begin
                n_hm   = ew_hm;
                n_lat  = ew_lat;
                n_lon  = ew_lon;
                n_sats = ew_sats;
                if (r_word < WI_W'(MAX_WORDS - 1)) n_word = r_word + WI_W'(1);
                n_char = '0;
                n_fcnt = 3'd0;
                n_deg  = 10'd0;
                n_min  = 7'd0;
                n_frac = 14'd0;
            end else if (r_char < CI_W'(MAX_WORD_CHARS)) begin
                n_char = r_char + CI_W'(1);
                if (r_word == '0) begin
                    if (r_hm != nsp_pkg::HM_OTHER) begin
                        if (!k_lt6) begin
                            n_hm = nsp_pkg::HM_OTHER;
                        end else if (r_hm == nsp_pkg::HM_PREFIX) begin
                            if (k3 < 3'd3) begin
                                if (c != nsp_pkg::f_hdr_char(1'b0, k3)) n_hm = nsp_pkg::HM_OTHER;
                            end else if (c == nsp_pkg::f_hdr_char(1'b0, k3)) begin
                                n_hm = nsp_pkg::HM_GGA;
                            end else if (c == nsp_pkg::f_hdr_char(1'b1, k3)) begin
                                n_hm = nsp_pkg::HM_RMC;
                            end else begin
                                n_hm = nsp_pkg::HM_OTHER;
                            end
                        end else if (c != nsp_pkg::f_hdr_char(is_rmc, k3)) begin
                            n_hm = nsp_pkg::HM_OTHER;
                        end
                    end
                end else if (r_word == WI_W'(1)) begin
                    if (k_lt6) begin
                        if (!r_char[0]) n_td[slot] = 7'(d) * 7'd10;
                        else n_td[slot] = r_td[slot] + 7'(d);
                    end
                end else if (is_gga) begin
                    if (r_word == WI_W'(2) || r_word == WI_W'(4) || r_word == WI_W'(7)) begin
                        if (c == nsp_pkg::C_DOT && r_fcnt == 3'd0) begin
                            n_fcnt = 3'd1;
                        end else if (nsp_pkg::f_is_digit(c)) begin
                            if (r_fcnt == 3'd0) begin
                                // integer part saturates at 99999
                                if (deg_next > 14'd999) begin
                                    n_deg = 10'd999;
                                    n_min = 7'd99;
                                end else begin
                                    n_deg = deg_next[9:0];
                                    n_min = min_next[6:0];
                                end
                            end else if (r_fcnt < 3'd5) begin
                                n_frac = r_frac + 14'(d) * 14'(nsp_pkg::f_frac_weight(r_fcnt));
                                n_fcnt = r_fcnt + 3'd1;
                            end
                        end
                    end else if (r_word == WI_W'(3) && k_zero) begin
                        n_south = c == nsp_pkg::C_SOUTH;
                    end else if (r_word == WI_W'(5) && k_zero) begin
                        n_west = c == nsp_pkg::C_WEST;
                    end else if (r_word == WI_W'(6) && k_zero && c == nsp_pkg::C_ZERO) begin
                        n_fix = 1'b0;
                    end
                end else if (is_rmc) begin
                    if (r_word == WI_W'(2) && k_zero && c == nsp_pkg::C_VOID) begin
                        n_fix = 1'b0;
                    end else if (r_word == WI_W'(9) && k_lt6) begin
                        if (!r_char[0]) n_td[slot + 3'd3] = 7'(d) * 7'd10;
                        else n_td[slot + 3'd3] = r_td[slot + 3'd3] + 7'(d);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_char  <= n_char;
        r_hm    <= n_hm;
        r_td    <= n_td;
        r_lat   <= n_lat;
        r_lon   <= n_lon;
        r_fix   <= n_fix;
        r_south <= n_south;
        r_west  <= n_west;
        r_sats  <= n_sats;
        r_fcnt  <= n_fcnt;
        r_deg   <= n_deg;
        r_min   <= n_min;
        r_frac  <= n_frac;
    end

endmodule
`default_nettype wire

// ===== hdl/nmea_sentence_parser.sv =====
// nmea_sentence_parser: top level, sentence framing, commit of stored values, result register
// depends on nsp_pkg, nsp_checksum, nsp_field_decoder
`default_nettype none
// Takes one NMEA character per request and gives one result per CR or LF that ends a
// sentence started by '$'. A byte is taken in every unstalled clock cycle: all parsing is done
// incrementally in the cycle the byte is accepted, and the result register is loaded in that
// same cycle. Only a line-end byte waits while an earlier result is still untaken; other bytes
// keep flowing. GGA time, position and satellites and RMC date are committed to the stored
// values only on a matching checksum, and each result shows the stored values after commit.
module nmea_sentence_parser #(
    parameter int MAX_WORDS      = nsp_pkg::MAX_WORDS_DEF,
    parameter int MAX_WORD_CHARS = nsp_pkg::MAX_WORD_CHARS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_rx_valid,
    output logic                                 o_rx_ready,
    input  wire logic [7:0]                      i_rx_byte,
    output logic                                 o_res_valid,
    input  wire logic                            i_res_ready,
    output logic [1:0]                           o_sentence_kind,
    output logic                                 o_checksum_ok,
    output logic                                 o_fix_valid,
    output logic [6:0]                           o_utc_hour,
    output logic [6:0]                           o_utc_minute,
    output logic [6:0]                           o_utc_second,
    output logic [6:0]                           o_date_day,
    output logic [6:0]                           o_date_month,
    output logic [6:0]                           o_date_year,
    output logic signed [nsp_pkg::LAT_W-1:0]     o_latitude_position,
    output logic signed [nsp_pkg::LON_W-1:0]     o_longitude_position,
    output logic [6:0]                           o_satellites_used
);

    localparam int LAT_W = nsp_pkg::LAT_W;
    localparam int LON_W = nsp_pkg::LON_W;

    logic r_in_sentence, n_in_sentence;
    logic r_res_valid, n_res_valid;
    logic [1:0] r_kind;
    logic r_ok;
    logic r_fix;
    logic [6:0] r_hour, r_minute, r_second, r_day, r_month, r_year, r_sats;
    logic signed [LAT_W-1:0] r_lat;
    logic signed [LON_W-1:0] r_lon;

    nsp_pkg::t_byte_ev ev;
    nsp_pkg::t_fields  fields;
    logic accept;
    logic is_eol;
    logic eol_fire;
    logic ok;
    logic [1:0] kind;

    assign is_eol = (i_rx_byte == nsp_pkg::C_CR) || (i_rx_byte == nsp_pkg::C_LF);
    // only a line end needs the result register
    assign o_rx_ready = !r_res_valid || i_res_ready || !(r_in_sentence && is_eol);
    assign accept     = i_rx_valid && o_rx_ready;
    assign eol_fire   = accept && r_in_sentence && is_eol;

    assign ev.start = accept && (i_rx_byte == nsp_pkg::C_DOLLAR);
    assign ev.take  = accept && r_in_sentence && !is_eol && (i_rx_byte != nsp_pkg::C_DOLLAR);
    assign ev.ch    = i_rx_byte;

    nsp_checksum u_checksum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ev    (ev),
        .o_ok    (ok)
    );

    nsp_field_decoder #(
        .MAX_WORDS      (MAX_WORDS),
        .MAX_WORD_CHARS (MAX_WORD_CHARS)
    ) u_fields (
        .i_clk    (i_clk),
        .i_ev     (ev),
        .o_fields (fields)
    );

    always_comb begin
        unique case (fields.hm)
            nsp_pkg::HM_GGA: kind = nsp_pkg::KIND_GGA;
            nsp_pkg::HM_RMC: kind = nsp_pkg::KIND_RMC;
            default:         kind = nsp_pkg::KIND_OTHER;
        endcase
    end

    always_comb begin
        n_in_sentence = r_in_sentence;
        if (ev.start) n_in_sentence = 1'b1;
        else if (eol_fire) n_in_sentence = 1'b0;
        n_res_valid = r_res_valid;
        if (eol_fire) n_res_valid = 1'b1;
        else if (i_res_ready) n_res_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sentence <= 1'b0;
            r_res_valid   <= 1'b0;
            r_kind        <= nsp_pkg::KIND_OTHER;
            r_ok          <= 1'b0;
            r_fix         <= 1'b0;
            r_hour        <= 7'd0;
            r_minute      <= 7'd0;
            r_second      <= 7'd0;
            r_day         <= 7'd0;
            r_month       <= 7'd0;
            r_year        <= 7'd0;
            r_sats        <= 7'd0;
            r_lat         <= '0;
            r_lon         <= '0;
        end else begin
            r_in_sentence <= n_in_sentence;
            r_res_valid   <= n_res_valid;
            if (eol_fire) begin
                r_kind <= kind;
                r_ok   <= ok;
                r_fix  <= (kind != nsp_pkg::KIND_OTHER) && fields.fix;
                // stored values change only here, so they double as result fields
                if (ok && kind == nsp_pkg::KIND_GGA) begin
                    r_hour   <= fields.hour;
                    r_minute <= fields.minute;
                    r_second <= fields.second;
                    r_sats   <= fields.sats;
                    r_lat    <= fields.south ? LAT_W'(0) - {1'b0, fields.lat_mag}
                                             : {1'b0, fields.lat_mag};
                    r_lon    <= fields.west ? LON_W'(0) - {1'b0, fields.lon_mag}
                                            : {1'b0, fields.lon_mag};
                end else if (ok && kind == nsp_pkg::KIND_RMC) begin
                    r_day   <= fields.day;
                    r_month <= fields.month;
                    r_year  <= fields.year;
                end
            end
        end
    end

    assign o_res_valid          = r_res_valid;
    assign o_sentence_kind      = r_kind;
    assign o_checksum_ok        = r_ok;
    assign o_fix_valid          = r_fix;
    assign o_utc_hour           = r_hour;
    assign o_utc_minute         = r_minute;
    assign o_utc_second         = r_second;
    assign o_date_day           = r_day;
    assign o_date_month         = r_month;
    assign o_date_year          = r_year;
    assign o_latitude_position  = r_lat;
    assign o_longitude_position = r_lon;
    assign o_satellites_used    = r_sats;

endmodule
`default_nettype wire

// ===== tb/sv/nmea_sentence_parser_test.sv =====
// nmea_sentence_parser_test: self-checking bench for the nmea sentence parser
// drives byte requests and checks every result against a local sentence predictor
// depends on nsp_pkg and nmea_sentence_parser
`timescale 1ns / 1ps
`default_nettype none
module nmea_sentence_parser_test;

    localparam int NUM_WORDS = nsp_pkg::MAX_WORDS_DEF;
    localparam int NUM_CHARS = nsp_pkg::MAX_WORD_CHARS_DEF;
    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD = 400;
    localparam int NONE = -1;

    typedef enum int { FORM_GOOD, FORM_LOWER, FORM_RAW } t_form;

    typedef struct {
        t_form form;
        string body;
        int    kind;
        int    ok;
        int    fix;
    } t_row;

    typedef struct {
        logic [1:0]                kind;
        logic                      ok;
        logic                      fix;
        logic [6:0]                td [6];
        logic [nsp_pkg::LAT_W-1:0] lat;
        logic [nsp_pkg::LON_W-1:0] lon;
        logic [6:0]                sats;
    } t_sentence_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_rx_valid = 1'b0;
    logic [7:0]        i_rx_byte = 8'h00;
    logic              i_res_ready = 1'b0;
    logic              o_rx_ready, o_res_valid;
    logic [1:0]        o_sentence_kind;
    logic              o_checksum_ok, o_fix_valid;
    logic [6:0]        o_utc_hour, o_utc_minute, o_utc_second;
    logic [6:0]        o_date_day, o_date_month, o_date_year, o_satellites_used;
    logic signed [nsp_pkg::LAT_W-1:0] o_latitude_position;
    logic signed [nsp_pkg::LON_W-1:0] o_longitude_position;

    nmea_sentence_parser uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_rx_valid(i_rx_valid), .o_rx_ready(o_rx_ready), .i_rx_byte(i_rx_byte),
        .o_res_valid(o_res_valid), .i_res_ready(i_res_ready),
        .o_sentence_kind(o_sentence_kind), .o_checksum_ok(o_checksum_ok),
        .o_fix_valid(o_fix_valid), .o_utc_hour(o_utc_hour), .o_utc_minute(o_utc_minute),
        .o_utc_second(o_utc_second), .o_date_day(o_date_day), .o_date_month(o_date_month),
        .o_date_year(o_date_year), .o_latitude_position(o_latitude_position),
        .o_longitude_position(o_longitude_position), .o_satellites_used(o_satellites_used)
    );

    always #5 i_clk = ~i_clk;

    // sentence predictor state
    bit          in_sent, in_ck_region, taking_ck;
    logic [7:0]  calc_ck, rx_ck;
    int          rx_digits, word_no, char_no, frac_cnt;
    logic [1:0]  hdr_state;
    int unsigned int_acc, frac_acc, pend_lat, pend_lon;
    int          pend_td [6];
    bit          pend_fix, pend_south, pend_west;
    int          pend_sats;
    logic [6:0]  kept_td [6];
    logic [nsp_pkg::LAT_W-1:0] kept_lat;
    logic [nsp_pkg::LON_W-1:0] kept_lon;
    logic [6:0]  kept_sats;

    t_sentence_result pending_results [$];
    int  typed_kind = NONE, typed_ok = NONE, typed_fix = NONE;
    int  fails = 0;
    int  bytes_sent = 0;
    bit  quiet = 1'b0;
    bit  hold_req = 1'b0;
    int  idle_cycles = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int unsigned scaled_mag(int unsigned limit);
        int unsigned n, f, m;
        n = (frac_cnt != 0) ? frac_cnt - 1 : 0;
        f = frac_acc;
        for (; n < 4; n++) f = f * 10;
        m = (int_acc / 100) * 600000 + (int_acc % 100) * 10000 + f;
        return (m > limit) ? limit : m;
    endfunction

    function automatic int digit_val(logic [7:0] c);
        return (c >= "0" && c <= "9") ? int'(c - "0") : 0;
    endfunction

    task automatic clear_word();
        char_no = 0;
        int_acc = 0;
        frac_acc = 0;
        frac_cnt = 0;
    endtask

    task automatic number_char(logic [7:0] c);
        if (c == nsp_pkg::C_DOT && frac_cnt == 0) begin
            frac_cnt = 1;
        end else if (c >= "0" && c <= "9") begin
            if (frac_cnt == 0) begin
                int_acc = int_acc * 10 + digit_val(c);
                if (int_acc > 99999) int_acc = 99999;
            end else if (frac_cnt < 5) begin
                frac_acc = frac_acc * 10 + digit_val(c);
                frac_cnt++;
            end
        end
    endtask

    task automatic time_char(int slot, int k, logic [7:0] c);
        if (k % 2 == 0) pend_td[slot] = digit_val(c) * 10;
        else pend_td[slot] = pend_td[slot] + digit_val(c);
    endtask

    task automatic header_char(int k, logic [7:0] c);
        string gga, rmc;
        gga = "$GPGGA";
        rmc = "$GPRMC";
        if (hdr_state == nsp_pkg::HM_OTHER) return;
        if (k >= 6) begin
            hdr_state = nsp_pkg::HM_OTHER;
        end else if (hdr_state == nsp_pkg::HM_PREFIX) begin
            if (k < 3) begin
                if (c != gga[k]) hdr_state = nsp_pkg::HM_OTHER;
            end else if (c == gga[k]) begin
                hdr_state = nsp_pkg::HM_GGA;
            end else if (c == rmc[k]) begin
                hdr_state = nsp_pkg::HM_RMC;
            end else begin
                hdr_state = nsp_pkg::HM_OTHER;
            end
        end else if (hdr_state == nsp_pkg::HM_GGA) begin
            if (c != gga[k]) hdr_state = nsp_pkg::HM_OTHER;
        end else if (c != rmc[k]) begin
            hdr_state = nsp_pkg::HM_OTHER;
        end
    endtask

    task automatic word_char(logic [7:0] c);
        if (word_no == 0) begin
            header_char(char_no, c);
        end else if (word_no == 1) begin
            if (char_no < 6) time_char(char_no / 2, char_no, c);
        end else if (hdr_state == nsp_pkg::HM_GGA) begin
            if (word_no == 2 || word_no == 4 || word_no == 7) number_char(c);
            else if (word_no == 3 && char_no == 0) pend_south = (c == nsp_pkg::C_SOUTH);
            else if (word_no == 5 && char_no == 0) pend_west = (c == nsp_pkg::C_WEST);
            else if (word_no == 6 && char_no == 0 && c == nsp_pkg::C_ZERO) pend_fix = 1'b0;
        end else if (hdr_state == nsp_pkg::HM_RMC) begin
            if (word_no == 2 && char_no == 0 && c == nsp_pkg::C_VOID) pend_fix = 1'b0;
            else if (word_no == 9 && char_no < 6) time_char(3 + char_no / 2, char_no, c);
        end
    endtask

    task automatic close_word();
        if (word_no == 0) begin
            if (char_no != 6 || hdr_state == nsp_pkg::HM_PREFIX) hdr_state = nsp_pkg::HM_OTHER;
        end else if (hdr_state == nsp_pkg::HM_GGA) begin
            if (word_no == 2) pend_lat = scaled_mag(54000000);
            else if (word_no == 4) pend_lon = scaled_mag(108000000);
            else if (word_no == 7) pend_sats = (int_acc > 99) ? 99 : int_acc;
        end
    endtask

    task automatic open_sentence();
        in_sent = 1'b1;
        in_ck_region = 1'b1;
        taking_ck = 1'b0;
        calc_ck = 8'h00;
        rx_ck = 8'h00;
        rx_digits = 0;
        word_no = 0;
        clear_word();
        hdr_state = nsp_pkg::HM_PREFIX;
        char_no = 1;
        foreach (pend_td[i]) pend_td[i] = 0;
        pend_lat = 0;
        pend_lon = 0;
        pend_fix = 1'b1;
        pend_south = 1'b0;
        pend_west = 1'b0;
        pend_sats = 0;
    endtask

    task automatic take_hex_char(logic [7:0] c);
        int v;
        if (rx_digits >= 2) return;
        if (c >= "0" && c <= "9") v = c - "0";
        else if (c >= "A" && c <= "F") v = c - "A" + 10;
        else if (c >= "a" && c <= "f") v = c - "a" + 10;
        else begin
            rx_digits = 3;
            return;
        end
        rx_ck = {rx_ck[3:0], 4'(v)};
        rx_digits++;
    endtask

    task automatic parse_byte(logic [7:0] c);
        t_sentence_result r;
        if (c == nsp_pkg::C_DOLLAR) begin
            open_sentence();
            return;
        end
        if (!in_sent) return;
        if (c == nsp_pkg::C_CR || c == nsp_pkg::C_LF) begin
            close_word();
            in_sent = 1'b0;
            r.kind = (hdr_state == nsp_pkg::HM_GGA) ? nsp_pkg::KIND_GGA :
                     (hdr_state == nsp_pkg::HM_RMC) ? nsp_pkg::KIND_RMC : nsp_pkg::KIND_OTHER;
            r.ok = (rx_digits == 2 && rx_ck == calc_ck);
            r.fix = (r.kind != nsp_pkg::KIND_OTHER) && pend_fix;
            if (r.ok && r.kind == nsp_pkg::KIND_GGA) begin
                for (int i = 0; i < 3; i++) kept_td[i] = 7'(pend_td[i]);
                kept_lat = pend_south ? nsp_pkg::LAT_W'(-int'(pend_lat))
                                      : nsp_pkg::LAT_W'(pend_lat);
                kept_lon = pend_west ? nsp_pkg::LON_W'(-int'(pend_lon))
                                     : nsp_pkg::LON_W'(pend_lon);
                kept_sats = 7'(pend_sats);
            end else if (r.ok && r.kind == nsp_pkg::KIND_RMC) begin
                for (int i = 3; i < 6; i++) kept_td[i] = 7'(pend_td[i]);
            end
            r.td = kept_td;
            r.lat = kept_lat;
            r.lon = kept_lon;
            r.sats = kept_sats;
            // hand-typed values of a directed row stand in for the predicted ones
            if (typed_kind != NONE) r.kind = 2'(typed_kind);
            if (typed_ok != NONE) r.ok = typed_ok[0];
            if (typed_fix != NONE) r.fix = typed_fix[0];
            typed_kind = NONE;
            typed_ok = NONE;
            typed_fix = NONE;
            pending_results.push_back(r);
            return;
        end
        if (in_ck_region && c == nsp_pkg::C_STAR) in_ck_region = 1'b0;
        if (in_ck_region) calc_ck ^= c;
        if (taking_ck) take_hex_char(c);
        if (c == nsp_pkg::C_STAR) taking_ck = 1'b1;
        if (c == nsp_pkg::C_COMMA) begin
            close_word();
            if (word_no < NUM_WORDS - 1) word_no++;
            clear_word();
        end else if (char_no < NUM_CHARS) begin
            word_char(c);
            char_no++;
        end
    endtask

    // byte requests, entered and left at a falling edge
    task automatic send_byte(logic [7:0] b);
        int g;
        g = quiet ? 0 : pick_gap();
        if (g > 0) begin
            i_rx_valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_rx_valid = 1'b1;
        i_rx_byte = b;
        do @(posedge i_clk); while (!o_rx_ready);
        parse_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    function automatic string framed(string body, bit lower);
        logic [7:0] x;
        x = 8'h00;
        for (int i = 0; i < body.len(); i++) x ^= body[i];
        return {"$", body, "*", lower ? $sformatf("%02x", x) : $sformatf("%02X", x), "\r\n"};
    endfunction

    function automatic string digits(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        return s;
    endfunction

    function automatic string rand_coord();
        if ($urandom_range(0, 9) == 0) return "";
        return {digits($urandom_range(0, 5)), ".", digits($urandom_range(0, 6))};
    endfunction

    function automatic string rand_time();
        return {digits(6), $urandom_range(0, 1) ? {".", digits(2)} : ""};
    endfunction

    function automatic string rand_gga();
        string fixes [4];
        fixes = '{"0", "1", "2", ""};
        return {"GPGGA,", rand_time(), ",", rand_coord(), ",", $urandom_range(0, 1) ? "S" : "N",
                ",", rand_coord(), ",", $urandom_range(0, 1) ? "W" : "E", ",",
                fixes[$urandom_range(0, 3)], ",", digits($urandom_range(0, 3)),
                ",0.9,545.4,M,46.9,M,,"};
    endfunction

    function automatic string rand_rmc();
        return {"GPRMC,", rand_time(), ",", $urandom_range(0, 1) ? "V" : "A", ",",
                rand_coord(), ",N,", rand_coord(), ",E,022.4,084.4,", digits(6), ",003.1,W"};
    endfunction

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_sentence_result r;
        if (o_res_valid && i_res_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request waiting for one");
                fails++;
            end else begin
                r = pending_results.pop_front();
                check_field("sentence_kind", r.kind, o_sentence_kind);
                check_field("checksum_ok", r.ok, o_checksum_ok);
                check_field("fix_valid", r.fix, o_fix_valid);
                check_field("utc_hour", r.td[0], o_utc_hour);
                check_field("utc_minute", r.td[1], o_utc_minute);
                check_field("utc_second", r.td[2], o_utc_second);
                check_field("date_day", r.td[3], o_date_day);
                check_field("date_month", r.td[4], o_date_month);
                check_field("date_year", r.td[5], o_date_year);
                check_field("latitude_position", r.lat, $unsigned(o_latitude_position));
                check_field("longitude_position", r.lon, $unsigned(o_longitude_position));
                check_field("satellites_used", r.sats, o_satellites_used);
            end
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_res_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (stall > 0) begin
                i_res_ready = 1'b0;
                stall--;
            end else begin
                i_res_ready = 1'b1;
                if (!quiet) stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_rx_valid && o_rx_ready) || (o_res_valid && i_res_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_row rows [$];
        logic [7:0] noise [$];
        string s;
        int pick;
        for (int i = 0; i < 6; i++) kept_td[i] = 7'd0;
        kept_lat = '0;
        kept_lon = '0;
        kept_sats = '0;
        in_sent = 1'b0;
        hdr_state = nsp_pkg::HM_OTHER;

        rows.push_back('{FORM_GOOD,
            "GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,",
            nsp_pkg::KIND_GGA, 1, 1});
        rows.push_back('{FORM_GOOD,
            "GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W",
            nsp_pkg::KIND_RMC, 1, 1});
        // extreme position, saturation and a void fix
        rows.push_back('{FORM_GOOD,
            "GPGGA,235959.99,9999999.99999,S,18000.0000,W,0,12345,1,2,M,3,M,,",
            nsp_pkg::KIND_GGA, 1, 0});
        rows.push_back('{FORM_LOWER,
            "GPGGA,000000,0000.0001,N,00000.0001,E,2,00,,,,,,,", nsp_pkg::KIND_GGA, 1, 1});
        rows.push_back('{FORM_GOOD, "GPRMC,010203,V,,,,,,,311299,,", nsp_pkg::KIND_RMC, 1, 0});
        rows.push_back('{FORM_RAW, "$GPGGA,112233,1.5,N*G1\r\n", nsp_pkg::KIND_GGA, 0, 1});
        rows.push_back('{FORM_RAW, "$GPRMC,010203,V\r\n", nsp_pkg::KIND_RMC, 0, 0});
        rows.push_back('{FORM_RAW, "$GPGGA,1*4\n", nsp_pkg::KIND_GGA, 0, 1});
        rows.push_back('{FORM_GOOD, "GPGSV,3,1,11,03,03,111,00", nsp_pkg::KIND_OTHER, 1, 0});
        rows.push_back('{FORM_GOOD, "GPGG,1,2", nsp_pkg::KIND_OTHER, 1, 0});
        rows.push_back('{FORM_GOOD, "GPGGAX,1,2", nsp_pkg::KIND_OTHER, 1, 0});
        rows.push_back('{FORM_GOOD, "GPRMCC", nsp_pkg::KIND_OTHER, 1, 0});
        // outside a sentence: ignored
        rows.push_back('{FORM_RAW, "noise\r\n\n", NONE, NONE, NONE});
        // a restart drops the unfinished sentence
        rows.push_back('{FORM_RAW, "$GPGGA,12", NONE, NONE, NONE});
        rows.push_back('{FORM_GOOD, "GPRMC,1a2b3c,A,,,,,,,x9y8z7,", nsp_pkg::KIND_RMC, 1, 1});
        rows.push_back('{FORM_GOOD,
            "GPGGA,101010,12345678901234567890.5,N,1.2.3.4,E,,7a8,", nsp_pkg::KIND_GGA, 1, 1});
        s = {"GPGGA,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,16,17,18,19,20,",
             "21,22,23,24,25,26,27,28,29,30,31,32,33,34"};
        rows.push_back('{FORM_GOOD, s, nsp_pkg::KIND_GGA, 1, 1});
        rows.push_back('{FORM_GOOD, "GPGGA,,,,,,,,", nsp_pkg::KIND_GGA, 1, 1});
        rows.push_back('{FORM_RAW, "$GPRMC,,A*xyzw\r", nsp_pkg::KIND_RMC, 0, 1});

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) begin
            typed_kind = rows[i].kind;
            typed_ok = rows[i].ok;
            typed_fix = rows[i].fix;
            if (rows[i].form == FORM_RAW) send_text(rows[i].body);
            else send_text(framed(rows[i].body, rows[i].form == FORM_LOWER));
            typed_kind = NONE;
            typed_ok = NONE;
            typed_fix = NONE;
        end
        // control bytes and high bytes inside a sentence, then trailing text after the digits
        send_text("$GP");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text(",1*00zz\r\n");
        send_text({framed("GPGGA,5", 1'b0).substr(0, 10), "Q\r\n"});

        for (int n = 0; bytes_sent < 1300; n++) begin
            if (n == 5) hold_req = 1'b1;
            quiet = ($urandom_range(0, 9) < 2);
            if (n == 20) begin
                i_rx_valid = 1'b0;
                while (pending_results.size() != 0) @(negedge i_clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) s = framed(rand_gga(), $urandom_range(0, 1));
            else if (pick < 75) s = framed(rand_rmc(), $urandom_range(0, 1));
            else if (pick < 88) begin
                s = framed($urandom_range(0, 1) ? rand_gga() : rand_rmc(), 1'b0);
                s.putc($urandom_range(1, s.len() - 3), $urandom_range(1, 127));
            end else s = "";
            if (s.len() != 0) begin
                if ($urandom_range(0, 3) == 0) s = s.substr(0, s.len() - 2);
                send_text(s);
            end else begin
                noise.delete();
                repeat ($urandom_range(1, 12)) noise.push_back($urandom_range(0, 255));
                foreach (noise[i]) send_byte(noise[i]);
            end
        end
        quiet = 1'b0;
        i_rx_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fails == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
